// ===== hdl/des_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, the standard DES tables and permutation functions for the DES core.
// Used by des_key_sched, des_round_cell and des_block_cipher_core; no dependencies.
package des_pkg;

    // Data types.
    typedef logic [31:0] half_t;
    typedef logic [47:0] subkey_t;
    typedef logic [63:0] block_t;

    localparam int NUM_ROUNDS = 16;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_CIPHER_KEY   = 1'b0,
        CFG_DECRYPT_MODE = 1'b1
    } cfg_idx_t;

    // Initial permutation, bit numbers 1..64 counted from the MSB.
    localparam logic [6:0] TAB_IP [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    // Final permutation.
    localparam logic [6:0] TAB_FP [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    // Expansion E, 32 to 48 bits.
    localparam logic [5:0] TAB_E [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // Permutation P after the S-boxes.
    localparam logic [5:0] TAB_P [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // First key selection, 64 to 56 bits; parity bits are not selected.
    localparam logic [6:0] TAB_PC1 [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // Second key selection, from the rotated halves down to a 48-bit subkey.
    localparam logic [5:0] TAB_PC2 [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Total left rotation of the key halves after each round's shift.
    localparam logic [4:0] CUM_ROT [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    // The eight S-boxes, one per six-bit group, indexed by {row, column}.
    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    // Initial permutation; pure wiring.
    function automatic block_t ip_perm(input block_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = v[6'(7'd64 - TAB_IP[i])];
        end
        return r;
    endfunction

    // Final permutation; pure wiring.
    function automatic block_t fp_perm(input block_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = v[6'(7'd64 - TAB_FP[i])];
        end
        return r;
    endfunction

    // Expansion of the right half to 48 bits.
    function automatic subkey_t e_expand(input half_t v);
        subkey_t r;
        r = '0;
        for (int i = 0; i < 48; i++)
        begin
            r[47 - i] = v[5'(6'd32 - TAB_E[i])];
        end
        return r;
    endfunction

    // Permutation P on the S-box outputs.
    function automatic half_t p_perm(input half_t v);
        half_t r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            r[31 - i] = v[5'(6'd32 - TAB_P[i])];
        end
        return r;
    endfunction

    // First key selection on the full key.
    function automatic logic [55:0] pc1_perm(input block_t v);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++)
        begin
            r[55 - i] = v[6'(7'd64 - TAB_PC1[i])];
        end
        return r;
    endfunction

    // Second key selection on the rotated key halves.
    function automatic subkey_t pc2_perm(input logic [55:0] v);
        subkey_t r;
        r = '0;
        for (int i = 0; i < 48; i++)
        begin
            r[47 - i] = v[6'd56 - TAB_PC2[i]];
        end
        return r;
    endfunction

    // Left rotation of a 28-bit key half by a constant amount.
    function automatic logic [27:0] rot28(input logic [27:0] v, input logic [4:0] k);
        logic [55:0] doubled;
        doubled = {v, v};
        return doubled[6'd55 - {1'b0, k} -: 28];
    endfunction

    // Feistel function: expansion, subkey mix, S-boxes, then P.
    function automatic half_t feistel(input half_t r, input subkey_t sub);
        subkey_t x;
        logic [5:0] six;
        half_t o;
        x = e_expand(r) ^ sub;
        o = '0;
        for (int j = 0; j < 8; j++)
        begin
            six = x[47 - 6 * j -: 6];
            o[31 - 4 * j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
        end
        return p_perm(o);
    endfunction

endpackage

// ===== hdl/des_block_cipher_core.sv =====
`timescale 1ns / 1ps
// DES core: sixteen round cells in a chain, one Feistel round per cell and clock.
// A block passes through 16 registered stages, one per round cell, before its result is shown.
// Throughput: one block per cycle when not stalled; each stage holds while its successor is stalled and full.
// Reset clears all stage valid bits, the key (to zero) and the mode (to encrypt).
// Depends on des_pkg, des_key_sched and des_round_cell.
module des_block_cipher_core
    import des_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_write,
    input  logic   cfg_index,
    input  block_t cfg_data,
    input  logic   block_in_valid,
    output logic   block_in_stall,
    input  block_t block_in,
    output logic   block_out_valid,
    input  logic   block_out_stall,
    output block_t block_out
);

    block_t  key_reg;
    logic    decrypt_reg;
    subkey_t round_key [NUM_ROUNDS];
    block_t  ip_block;
    half_t   chain_l [NUM_ROUNDS + 1];
    half_t   chain_r [NUM_ROUNDS + 1];
    logic [NUM_ROUNDS:0] chain_valid;
    logic [NUM_ROUNDS:0] chain_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            decrypt_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CIPHER_KEY:   key_reg     <= cfg_data;
                CFG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
            endcase
        end
    end

    // Round keys from the static key.
    des_key_sched u_key_sched (
        .cipher_key   (key_reg),
        .decrypt_mode (decrypt_reg),
        .round_key    (round_key)
    );

    // Chain head: initial permutation of the incoming block.
    assign ip_block       = ip_perm(block_in);
    assign chain_l[0]     = ip_block[63:32];
    assign chain_r[0]     = ip_block[31:0];
    assign chain_valid[0] = block_in_valid;
    assign block_in_stall = !chain_ready[0];

    // Sixteen round cells.
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_cell
        des_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_l       (chain_l[i]),
            .up_r       (chain_r[i]),
            .up_ready   (chain_ready[i]),
            .round_key  (round_key[i]),
            .down_valid (chain_valid[i + 1]),
            .down_l     (chain_l[i + 1]),
            .down_r     (chain_r[i + 1]),
            .down_ready (chain_ready[i + 1])
        );
    end

    // Chain tail: swap halves and apply the final permutation.
    assign chain_ready[NUM_ROUNDS] = !block_out_stall;
    assign block_out_valid         = chain_valid[NUM_ROUNDS];
    assign block_out = fp_perm({chain_r[NUM_ROUNDS], chain_l[NUM_ROUNDS]});

`ifndef SYNTHESIS
    // An empty last stage lets the whole chain move, so input is never held off.
    a_empty_tail_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !block_out_valid |-> !block_in_stall)
        else $error("input stalled while last stage is empty");

    // A completely full chain with a stalled output must hold off input.
    a_full_chain_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (&chain_valid[NUM_ROUNDS:1] && block_out_stall) |-> block_in_stall)
        else $error("input accepted into a full, stalled chain");

    // An accepted block with no departing result raises occupancy by one.
    a_occupancy_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (block_in_valid && !block_in_stall && !(block_out_valid && !block_out_stall))
        |=> ($countones(chain_valid[NUM_ROUNDS:1])
             == $past($countones(chain_valid[NUM_ROUNDS:1])) + 1))
        else $error("block lost or duplicated in round chain");

    // With neither side moving, occupancy is unchanged.
    a_occupancy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!(block_in_valid && !block_in_stall) && !(block_out_valid && !block_out_stall))
        |=> $stable($countones(chain_valid[NUM_ROUNDS:1])))
        else $error("round chain occupancy changed without a transaction");
`endif

endmodule

// ===== hdl/des_key_sched.sv =====
`timescale 1ns / 1ps
// DES key schedule: PC-1, fixed rotations and PC-2 for all sixteen round keys.
// Depends on des_pkg; wiring plus a mux. Users keep the key static between blocks.
module des_key_sched
    import des_pkg::*;
(
    input  block_t  cipher_key,
    input  logic    decrypt_mode,
    output subkey_t round_key [NUM_ROUNDS]
);

    logic [55:0] cd0;
    subkey_t     enc_key [NUM_ROUNDS];

    // Halves after PC-1; parity bits drop out here.
    assign cd0 = pc1_perm(cipher_key);

    // Each round's subkey uses the cumulative rotation up to that round.
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_round
        assign enc_key[i] = pc2_perm({rot28(cd0[55:28], CUM_ROT[i]),
                                      rot28(cd0[27:0], CUM_ROT[i])});
        // Decryption walks the schedule backwards.
        assign round_key[i] = decrypt_mode ? enc_key[NUM_ROUNDS - 1 - i] : enc_key[i];
    end

endmodule

// ===== hdl/des_round_cell.sv =====
`timescale 1ns / 1ps
// One Feistel round as a pipeline cell with its own valid bit and stall ripple.
// Depends on des_pkg for the Feistel function and data types.
module des_round_cell
    import des_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  half_t   up_l,
    input  half_t   up_r,
    output logic    up_ready,
    input  subkey_t round_key,
    output logic    down_valid,
    output half_t   down_l,
    output half_t   down_r,
    input  logic    down_ready
);

    logic  valid_reg;
    half_t l_reg;
    half_t r_reg;
    half_t l_next;
    half_t r_next;

    // The cell can take a transaction when empty or when its content moves on.
    assign up_ready = !valid_reg || down_ready;

    // Round function: swap halves and mix the old right half into the left.
    assign l_next = up_r;
    assign r_next = up_l ^ feistel(up_r, round_key);

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Data halves load only on an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_l     = l_reg;
    assign down_r     = r_reg;

endmodule

// ===== tb/des_block_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for des_block_cipher_core: DES encryption and decryption.
// It computes every expected block with its own DES model and its own tables.
// Depends on des_pkg for the block type and the register indexes.
module des_block_cipher_core_tb;
    import des_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_BLOCKS = 128;

    // Offsets of the bit-selection tables inside BIT_MAP; bit 1 is the MSB.
    localparam int IP_AT = 0;
    localparam int FP_AT = 64;
    localparam int E_AT = 128;
    localparam int P_AT = 176;
    localparam int PC1_AT = 208;
    localparam int PC2_AT = 264;

    localparam int unsigned BIT_MAP [312] = '{
        // Initial permutation.
        58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
        62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
        57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
        61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7,
        // Final permutation.
        40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
        38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
        36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
        34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25,
        // Expansion.
        32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11, 12, 13,
        12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1,
        // P permutation.
        16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
        2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25,
        // Permuted choice 1.
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4,
        // Permuted choice 2.
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10, 23, 19, 12, 4, 26, 8,
        16, 7, 27, 20, 13, 2, 41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // One word per S-box row; the nibble for column 0 is the top nibble.
    localparam logic [63:0] SBOX_ROWS [32] = '{
        64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
        64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
        64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
        64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
        64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
        64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
        64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
        64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
    };

    // Left shifts of the key halves before each round.
    localparam int ROT_STEP [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_write = 1'b0;
    logic   cfg_index = 1'b0;
    block_t cfg_data = '0;
    logic   block_in_valid = 1'b0;
    logic   block_in_stall;
    block_t block_in = '0;
    logic   block_out_valid;
    logic   block_out_stall = 1'b0;
    block_t block_out;

    // Copy of the configuration as the block should hold it.
    block_t key_shadow = '0;
    logic   mode_shadow = 1'b0;

    block_t pending_blocks [$];
    block_t expected_blocks [$];
    int     queued_count = 0;
    int     accepted_count = 0;
    int     fail_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    des_block_cipher_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .block_in_valid  (block_in_valid),
        .block_in_stall  (block_in_stall),
        .block_in        (block_in),
        .block_out_valid (block_out_valid),
        .block_out_stall (block_out_stall),
        .block_out       (block_out)
    );

    always #2 clk = ~clk;

    // Gathers n bits of a width-bit value in the order that a table gives.
    function automatic logic [63:0] pick_bits(logic [63:0] v, int width, int base, int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            r = {r[62:0], v[width - BIT_MAP[base + i]]};
        end
        return r;
    endfunction

    // Round function: expand, mix in the subkey, substitute, permute.
    function automatic logic [31:0] round_mix(logic [31:0] r, logic [47:0] subkey);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] o;
        x = 48'(pick_bits(64'(r), 32, E_AT, 48)) ^ subkey;
        o = '0;
        for (int j = 0; j < 8; j++)
        begin
            six = x[47 - 6 * j -: 6];
            o = {o[27:0], SBOX_ROWS[j * 4 + {six[5], six[0]}][63 - 4 * six[4:1] -: 4]};
        end
        return 32'(pick_bits(64'(o), 32, P_AT, 32));
    endfunction

    // Full DES on one block under the given key and direction.
    function automatic block_t des_transform(block_t blk, block_t key, logic decrypt);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [47:0] subkeys [16];
        block_t      b;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        cd = 56'(pick_bits(key, 64, PC1_AT, 56));
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++)
        begin
            for (int k = 0; k < ROT_STEP[i]; k++)
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            subkeys[i] = 48'(pick_bits(64'({c, d}), 56, PC2_AT, 48));
        end
        b = pick_bits(blk, 64, IP_AT, 64);
        l = b[63:32];
        r = b[31:0];
        for (int i = 0; i < 16; i++)
        begin
            t = r;
            r = l ^ round_mix(r, decrypt ? subkeys[15 - i] : subkeys[i]);
            l = t;
        end
        return pick_bits({r, l}, 64, FP_AT, 64);
    endfunction

    // Sender: presents queued blocks and records the expected result of each
    // accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_in_valid <= 1'b0;
            block_in <= '0;
        end
        else
        begin
            if (block_in_valid && !block_in_stall)
            begin
                expected_blocks.push_back(des_transform(block_in, key_shadow, mode_shadow));
                accepted_count++;
            end
            if (!block_in_valid || !block_in_stall)
            begin
                if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    block_in <= pending_blocks.pop_front();
                    block_in_valid <= 1'b1;
                end
                else
                begin
                    block_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each accepted result transaction.
    always @(posedge clk or negedge rst_n)
    begin
        block_t want;
        if (!rst_n)
        begin
            block_out_stall <= 1'b0;
        end
        else
        begin
            if (block_out_valid && !block_out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("block_out: unexpected transaction, actual %h", block_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (block_out !== want)
                    begin
                        $error("block_out mismatch: expected %h, actual %h", want, block_out);
                        fail_count++;
                    end
                end
            end
            block_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_block(block_t b);
        pending_blocks.push_back(b);
        queued_count++;
    endtask

    // Waits until every queued block is accepted and every result has come back.
    task automatic drain();
        while (accepted_count != queued_count || expected_blocks.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(cfg_idx_t idx, block_t data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_CIPHER_KEY)
        begin
            key_shadow = data;
        end
        else
        begin
            mode_shadow = data[0];
        end
    endtask

    // Reprograms both registers on an idle block; only bit 0 of the mode word counts.
    task automatic apply_config(block_t key, block_t mode_word);
        drain();
        write_register(CFG_CIPHER_KEY, key);
        write_register(CFG_DECRYPT_MODE, mode_word);
        @(negedge clk);
    endtask

    function automatic block_t random_block();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return block_t'(1) << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        // The local tables must reproduce the classic published test vector.
        if (des_transform(64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 1'b0)
            !== 64'h85E813540F0AB405)
        begin
            $error("des_transform: known-answer vector does not match");
            fail_count++;
        end

        send_idle_pct = 12;
        recv_stall_pct = 60;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: all-zero key, encryption.
        queue_block('0);
        queue_block('1);

        // Textbook key; the mode word carries set upper bits with bit 0 clear.
        apply_config(64'h133457799BBCDFF1, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_block(64'h0123456789ABCDEF);
        queue_block('0);
        queue_block('1);

        // Same key with every parity bit inverted must give the same ciphertext.
        apply_config(64'h133457799BBCDFF1 ^ 64'h0101010101010101, '0);
        queue_block(64'h0123456789ABCDEF);

        // Decryption, mode word with noise in the upper bits.
        apply_config(64'h133457799BBCDFF1, 64'hAAAA_AAAA_AAAA_AAAB);
        queue_block(64'h85E813540F0AB405);

        // Weak keys are handled like any other.
        apply_config(64'h0101010101010101, '0);
        queue_block('0);
        queue_block(64'h0123456789ABCDEF);
        apply_config(64'hFEFEFEFEFEFEFEFE, 64'h1);
        queue_block('0);
        queue_block(64'h0123456789ABCDEF);
        apply_config(64'hE0E0E0E0F1F1F1F1, '0);
        queue_block(64'hFEDCBA9876543210);
        apply_config(64'h1F1F1F1F0E0E0E0E, 64'h1);
        queue_block(64'hFEDCBA9876543210);

        // Key extremes.
        apply_config('1, 64'h1);
        queue_block('0);
        queue_block('1);
        queue_block(64'h8000000000000000);
        queue_block(64'h0000000000000001);
        apply_config('0, '0);
        queue_block(64'h5555555555555555);
        queue_block(64'hAAAAAAAAAAAAAAAA);

        // Random keys, directions and blocks under three idling patterns.
        for (int seg = 0; seg < 9; seg++)
        begin
            apply_config({$urandom, $urandom}, {$urandom, $urandom});
            if (seg == 3)
            begin
                send_idle_pct = 60;
                recv_stall_pct = 12;
            end
            else if (seg == 6)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < SEGMENT_BLOCKS; n++)
            begin
                queue_block(random_block());
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
